// ===== rtl/aeu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeu_pkg : shared types and constants of the Adam update unit
// Store geometry, fixed-point constants, register and request codes, and the
// request/response bundles of the divider and square-root pipelines.
// ----------------------------------------------------------------------------
package aeu_pkg;

    // Moment store depth; a power of two, the slot is the index modulo it.
    localparam int ELEMENTS = 4096;
    localparam int SLOT_W   = $clog2(ELEMENTS);

    localparam int IDX_W  = 12;
    localparam int DATA_W = 32;
    localparam int RATE_W = 24;
    localparam int BETA_W = 24;
    localparam int EPS_W  = 16;
    localparam int POW_W  = 25;

    localparam logic [POW_W-1:0] ONE_Q24  = 25'h1000000;
    localparam logic [POW_W-1:0] HALF_Q24 = 25'h0800000;

    localparam logic [BETA_W-1:0] BETA_FIRST_RST  = 24'd15099494;
    localparam logic [BETA_W-1:0] BETA_SECOND_RST = 24'd16760438;
    localparam logic [EPS_W-1:0]  EPSILON_RST     = 16'd1;

    // Request codes
    localparam logic REQ_BEGIN_STEP = 1'b0;
    localparam logic REQ_ELEMENT    = 1'b1;

    // Configuration register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_BETA_FIRST  = 2'd0,
        REG_BETA_SECOND = 2'd1,
        REG_EPSILON     = 2'd2
    } reg_idx_t;

    localparam int PADDR_W = 4;

    // Elements in flight between the store read and the output register
    localparam int INFLIGHT_W = 8;

    // Divider: quotient bits, numerator and divisor widths, side-band width
    localparam int DIV_NW = 64;
    localparam int DIV_DW = 41;
    localparam int DIV_QW = 48;
    localparam int DIV_TW = DATA_W + IDX_W + 1;

    // Square root: radicand and root widths, side-band width
    localparam int SQ_XW = 64;
    localparam int SQ_RW = 32;
    localparam int MH_W  = 39;
    localparam int SQ_TW = MH_W + DATA_W + IDX_W + 1;

    typedef struct packed {
        logic              valid;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
        logic [DIV_TW-1:0] tag;
    } div_req_t;

    typedef struct packed {
        logic              valid;
        logic              ovf;
        logic [DIV_QW-1:0] quot;
        logic [DIV_TW-1:0] tag;
    } div_rsp_t;

    typedef struct packed {
        logic             valid;
        logic [SQ_XW-1:0] x;
        logic [SQ_TW-1:0] tag;
    } sq_req_t;

    typedef struct packed {
        logic             valid;
        logic [SQ_RW-1:0] root;
        logic [SQ_TW-1:0] tag;
    } sq_rsp_t;

endpackage

// ===== rtl/aeu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeu_ram : generic simple dual-port RAM
// One write port, one read port, read data registered; data holds while no
// read is issued.
// ----------------------------------------------------------------------------
module aeu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/aeu_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeu_div : pipelined restoring divider
// One quotient bit per stage; flags quotients that do not fit the quotient
// width. Carries the divisor and a side-band tag along with each beat.
// ----------------------------------------------------------------------------
module aeu_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  aeu_pkg::div_req_t req,
    output aeu_pkg::div_rsp_t rsp
);

    localparam int NW = aeu_pkg::DIV_NW;
    localparam int DW = aeu_pkg::DIV_DW;
    localparam int QW = aeu_pkg::DIV_QW;
    localparam int TW = aeu_pkg::DIV_TW;

    logic          vld_reg [0:QW];
    logic          ovf_reg [0:QW];
    logic [DW-1:0] rem_reg [0:QW];
    logic [QW-1:0] nq_reg  [0:QW];
    logic [DW-1:0] den_reg [0:QW];
    logic [TW-1:0] tag_reg [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= DW'(req.num[NW-1:QW]);
            nq_reg[0]  <= req.num[QW-1:0];
            den_reg[0] <= req.den;
            ovf_reg[0] <= (DW'(req.num[NW-1:QW]) >= req.den);
            tag_reg[0] <= req.tag;
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [DW:0] rem_sh;
        logic        ge;

        assign rem_sh = {rem_reg[s], nq_reg[s][QW-1]};
        assign ge     = (rem_sh >= {1'b0, den_reg[s]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s+1] <= ge ? DW'(rem_sh - {1'b0, den_reg[s]}) : DW'(rem_sh);
                nq_reg[s+1]  <= {nq_reg[s][QW-2:0], ge};
                den_reg[s+1] <= den_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
                tag_reg[s+1] <= tag_reg[s];
            end
        end
    end

    assign rsp.valid = vld_reg[QW];
    assign rsp.ovf   = ovf_reg[QW];
    assign rsp.quot  = nq_reg[QW];
    assign rsp.tag   = tag_reg[QW];

endmodule

// ===== rtl/aeu_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeu_sqrt : pipelined integer square root
// One root bit per stage, two radicand bits consumed per stage; floor result.
// ----------------------------------------------------------------------------
module aeu_sqrt (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  aeu_pkg::sq_req_t req,
    output aeu_pkg::sq_rsp_t rsp
);

    localparam int XW = aeu_pkg::SQ_XW;
    localparam int RW = aeu_pkg::SQ_RW;
    localparam int TW = aeu_pkg::SQ_TW;
    localparam int MW = RW + 2;

    logic          vld_reg  [0:RW];
    logic [MW-1:0] rem_reg  [0:RW];
    logic [RW-1:0] root_reg [0:RW];
    logic [XW-1:0] x_reg    [0:RW];
    logic [TW-1:0] tag_reg  [0:RW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            x_reg[0]    <= req.x;
            tag_reg[0]  <= req.tag;
        end
    end

    for (genvar s = 0; s < RW; s++)
    begin : g_stage
        logic [MW+1:0] rem_sh;
        logic [MW+1:0] trial;
        logic          ge;

        assign rem_sh = {rem_reg[s], x_reg[s][XW-1:XW-2]};
        assign trial  = (MW+2)'({root_reg[s], 2'b01});
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[s+1] <= vld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s+1]  <= ge ? MW'(rem_sh - trial) : MW'(rem_sh);
                root_reg[s+1] <= {root_reg[s][RW-2:0], ge};
                x_reg[s+1]    <= {x_reg[s][XW-3:0], 2'b00};
                tag_reg[s+1]  <= tag_reg[s];
            end
        end
    end

    assign rsp.valid = vld_reg[RW];
    assign rsp.root  = root_reg[RW];
    assign rsp.tag   = tag_reg[RW];

endmodule

// ===== rtl/adam_elementwise_update_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_elementwise_update_unit : fixed-point Adam optimiser update engine
// Keeps first and second moments per element in two RAMs, updates them by
// read-modify-write, applies bias correction, divides by root plus epsilon
// and returns the new parameter, saturated.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          beat contents
//  --------  ---------  -----------------  ---------------------------------
//  request   in         in_valid/in_ready  req_type, element_index, gradient,
//                                          param_value, step_lr
//  result    out        out_valid/out_ready result_index, new_param_value
//  config    in         APB, pready tied   beta_first, beta_second, epsilon
//
//  Element beats are taken one per cycle while the pipeline advances and no
//  slot hazard holds them; on its way a result passes five store stages,
//  the bias-correction dividers (49 register stages), the root (33), one
//  product stage and the step divider (49).
//  An element whose slot matches one of the four previous elements waits until
//  that element has written its moments back (read-modify-write window).
//  A begin-step beat waits until no element is in flight.
//  After reset the moment RAMs are swept to zero, one slot a cycle, through all
//  ELEMENTS (4096) slots; request beats are held off, config writes are taken.
//  A stalled result only freezes the pipeline when its last stage is occupied.
// ----------------------------------------------------------------------------
module adam_elementwise_update_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             req_type,
    input  logic [aeu_pkg::IDX_W-1:0]        element_index,
    input  logic signed [aeu_pkg::DATA_W-1:0] gradient,
    input  logic signed [aeu_pkg::DATA_W-1:0] param_value,
    input  logic [aeu_pkg::RATE_W-1:0]       step_lr,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [aeu_pkg::IDX_W-1:0]        result_index,
    output logic signed [aeu_pkg::DATA_W-1:0] new_param_value,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [aeu_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int SW = aeu_pkg::SLOT_W;
    localparam int IW = aeu_pkg::IDX_W;
    localparam int DW = aeu_pkg::DATA_W;
    localparam int BW = aeu_pkg::BETA_W;
    localparam int PW = aeu_pkg::POW_W;
    localparam int RW = aeu_pkg::RATE_W;
    localparam int EW = aeu_pkg::EPS_W;
    localparam int MW = aeu_pkg::MH_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [BW-1:0] beta1_reg;
    logic [BW-1:0] beta2_reg;
    logic [EW-1:0] eps_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta1_reg <= aeu_pkg::BETA_FIRST_RST;
            beta2_reg <= aeu_pkg::BETA_SECOND_RST;
            eps_reg   <= aeu_pkg::EPSILON_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                aeu_pkg::REG_BETA_FIRST:  beta1_reg <= pwdata[BW-1:0];
                aeu_pkg::REG_BETA_SECOND: beta2_reg <= pwdata[BW-1:0];
                aeu_pkg::REG_EPSILON:     eps_reg   <= pwdata[EW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            aeu_pkg::REG_BETA_FIRST:  prdata = 32'(beta1_reg);
            aeu_pkg::REG_BETA_SECOND: prdata = 32'(beta2_reg);
            aeu_pkg::REG_EPSILON:     prdata = 32'(eps_reg);
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control: clearing sweep, in-flight count, advance and accept
    // ------------------------------------------------------------------
    logic [SW:0]                      clr_cnt_reg;
    logic                             clearing;
    logic [aeu_pkg::INFLIGHT_W-1:0]   inflight_reg;
    logic                             adv;
    logic                             last_vld;
    logic                             hazard;
    logic                             acc;
    logic                             acc_elem;
    logic                             acc_step;
    logic [SW-1:0]                    in_slot;

    // Pipeline stage registers S1..S5 around the moment RAMs
    logic          s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    logic [SW-1:0] s1_slot_reg, s2_slot_reg, s3_slot_reg, s4_slot_reg;

    assign clearing = (clr_cnt_reg != (SW+1)'(aeu_pkg::ELEMENTS));
    assign in_slot  = SW'(element_index % aeu_pkg::ELEMENTS);

    // Hold the request while an older element of the same slot has not yet
    // written both moments back.
    assign hazard = (s1_vld_reg && s1_slot_reg == in_slot)
                 || (s2_vld_reg && s2_slot_reg == in_slot)
                 || (s3_vld_reg && s3_slot_reg == in_slot)
                 || (s4_vld_reg && s4_slot_reg == in_slot);

    // Freeze only when the last stage holds a result that has nowhere to go.
    assign adv = !out_valid || out_ready || !last_vld;

    always_comb
    begin
        if (clearing)
        begin
            in_ready = 1'b0;
        end
        else if (req_type == aeu_pkg::REQ_ELEMENT)
        begin
            in_ready = adv && !hazard;
        end
        else
        begin
            in_ready = (inflight_reg == '0);
        end
    end

    assign acc      = in_valid && in_ready;
    assign acc_elem = acc && (req_type == aeu_pkg::REQ_ELEMENT);
    assign acc_step = acc && (req_type == aeu_pkg::REQ_BEGIN_STEP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            inflight_reg <= '0;
        end
        else
        begin
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            case ({acc_elem, adv && last_vld})
                2'b10:   inflight_reg <= inflight_reg + 1'b1;
                2'b01:   inflight_reg <= inflight_reg - 1'b1;
                default: inflight_reg <= inflight_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Step state: running beta powers and latched rate
    // ------------------------------------------------------------------
    logic          stepped_reg;   // step count is non-zero
    logic [PW-1:0] pow1_reg, pow2_reg;
    logic [RW-1:0] rate_reg;
    logic [PW+BW-1:0] pow1_prod, pow2_prod;
    logic [PW-1:0] p1, p2, d1, d2;

    assign pow1_prod = (PW+BW)'(pow1_reg) * (PW+BW)'(beta1_reg) + (PW+BW)'(aeu_pkg::HALF_Q24);
    assign pow2_prod = (PW+BW)'(pow2_reg) * (PW+BW)'(beta2_reg) + (PW+BW)'(aeu_pkg::HALF_Q24);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stepped_reg <= 1'b0;
            pow1_reg    <= aeu_pkg::ONE_Q24;
            pow2_reg    <= aeu_pkg::ONE_Q24;
            rate_reg    <= '0;
        end
        else if (acc_step)
        begin
            stepped_reg <= 1'b1;
            pow1_reg    <= pow1_prod[PW+BW-1:BW];
            pow2_reg    <= pow2_prod[PW+BW-1:BW];
            rate_reg    <= step_lr;
        end
    end

    // Before the first step, correct as for step one. Steady while elements fly.
    assign p1 = stepped_reg ? pow1_reg : PW'(beta1_reg);
    assign p2 = stepped_reg ? pow2_reg : PW'(beta2_reg);
    assign d1 = (p1 >= aeu_pkg::ONE_Q24) ? PW'(1) : aeu_pkg::ONE_Q24 - p1;
    assign d2 = (p2 >= aeu_pkg::ONE_Q24) ? PW'(1) : aeu_pkg::ONE_Q24 - p2;

    // ------------------------------------------------------------------
    // Moment RAMs: sweep writes during clearing, else write-back
    // ------------------------------------------------------------------
    logic          m_we, v_we;
    logic [SW-1:0] m_waddr, v_waddr;
    logic [DW-1:0] m_wdata, v_wdata;
    logic [DW-1:0] m_rdata, v_rdata;
    logic signed [DW-1:0] mnew_c;
    logic [DW-1:0]        vnew_c;

    assign m_we    = clearing || (s2_vld_reg && adv);
    assign m_waddr = clearing ? clr_cnt_reg[SW-1:0] : s2_slot_reg;
    assign m_wdata = clearing ? '0 : DW'(mnew_c);
    assign v_we    = clearing || (s4_vld_reg && adv);
    assign v_waddr = clearing ? clr_cnt_reg[SW-1:0] : s4_slot_reg;
    assign v_wdata = clearing ? '0 : vnew_c;

    aeu_ram #(.WIDTH(DW), .DEPTH(aeu_pkg::ELEMENTS)) u_first_moment (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .re    (acc_elem),
        .raddr (in_slot),
        .rdata (m_rdata)
    );

    aeu_ram #(.WIDTH(DW), .DEPTH(aeu_pkg::ELEMENTS)) u_second_moment (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .re    (acc_elem),
        .raddr (in_slot),
        .rdata (v_rdata)
    );

    // ------------------------------------------------------------------
    // S1: moment read data arrives; form the blend and square products
    // ------------------------------------------------------------------
    logic [IW-1:0]        s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg, s5_idx_reg;
    logic signed [DW-1:0] s1_g_reg;
    logic signed [DW-1:0] s1_prm_reg, s2_prm_reg, s3_prm_reg, s4_prm_reg, s5_prm_reg;

    logic [PW-1:0]        c1, c2;
    logic signed [57:0]   pm1_c, pm2_c;
    logic [DW-1:0]        gmag_c;
    logic [63:0]          gg_c;

    assign c1     = aeu_pkg::ONE_Q24 - PW'(beta1_reg);
    assign c2     = aeu_pkg::ONE_Q24 - PW'(beta2_reg);
    assign pm1_c  = $signed({1'b0, beta1_reg}) * $signed(m_rdata);
    assign pm2_c  = $signed({1'b0, c1}) * s1_g_reg;
    assign gmag_c = s1_g_reg[DW-1] ? DW'(-s1_g_reg) : DW'(s1_g_reg);
    assign gg_c   = 64'(gmag_c) * 64'(gmag_c);

    // S2 registers
    logic signed [57:0] s2_pm1_reg, s2_pm2_reg;
    logic [63:0]        s2_gg_reg;
    logic [DW-1:0]      s2_vold_reg;

    // S2 combinational: round, floor, clamp the first moment; scale g squared
    logic signed [58:0] msum_c;
    logic signed [34:0] mshift_c;
    logic [63:0]        gsq_full_c;
    logic [DW-1:0]      gsq_c;

    assign msum_c     = 59'(s2_pm1_reg) + 59'(s2_pm2_reg) + 59'sd8388608;
    assign mshift_c   = 35'(msum_c >>> 24);
    assign gsq_full_c = (s2_gg_reg + 64'd32768) >> 16;
    assign gsq_c      = (|gsq_full_c[63:32]) ? '1 : gsq_full_c[DW-1:0];

    always_comb
    begin
        if (mshift_c > 35'sd2147483647)
        begin
            mnew_c = 32'sh7FFFFFFF;
        end
        else if (mshift_c < -35'sd2147483648)
        begin
            mnew_c = 32'sh80000000;
        end
        else
        begin
            mnew_c = DW'(mshift_c);
        end
    end

    // S3 registers: second-moment products come next
    logic signed [DW-1:0] s3_m_reg, s4_m_reg, s5_m_reg;
    logic [DW-1:0]        s3_gsq_reg, s3_vold_reg;
    logic [55:0]          pv1_c;
    logic [56:0]          pv2_c;

    assign pv1_c = 56'(s3_vold_reg) * 56'(beta2_reg);
    assign pv2_c = 57'(s3_gsq_reg) * 57'(c2);

    // S4 registers and second-moment round and saturate
    logic [55:0] s4_pv1_reg;
    logic [56:0] s4_pv2_reg;
    logic [57:0] vsum_c;

    assign vsum_c = 58'(s4_pv1_reg) + 58'(s4_pv2_reg) + 58'(aeu_pkg::HALF_Q24);
    assign vnew_c = (|vsum_c[57:56]) ? '1 : vsum_c[55:24];

    logic [DW-1:0] s5_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg <= acc_elem;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_slot_reg <= in_slot;
            s1_idx_reg  <= element_index;
            s1_g_reg    <= gradient;
            s1_prm_reg  <= param_value;

            s2_slot_reg <= s1_slot_reg;
            s2_idx_reg  <= s1_idx_reg;
            s2_prm_reg  <= s1_prm_reg;
            s2_pm1_reg  <= pm1_c;
            s2_pm2_reg  <= pm2_c;
            s2_gg_reg   <= gg_c;
            s2_vold_reg <= v_rdata;

            s3_slot_reg <= s2_slot_reg;
            s3_idx_reg  <= s2_idx_reg;
            s3_prm_reg  <= s2_prm_reg;
            s3_m_reg    <= mnew_c;
            s3_gsq_reg  <= gsq_c;
            s3_vold_reg <= s2_vold_reg;

            s4_slot_reg <= s3_slot_reg;
            s4_idx_reg  <= s3_idx_reg;
            s4_prm_reg  <= s3_prm_reg;
            s4_m_reg    <= s3_m_reg;
            s4_pv1_reg  <= pv1_c;
            s4_pv2_reg  <= pv2_c;

            s5_idx_reg  <= s4_idx_reg;
            s5_prm_reg  <= s4_prm_reg;
            s5_m_reg    <= s4_m_reg;
            s5_v_reg    <= vnew_c;
        end
    end

    // ------------------------------------------------------------------
    // Bias correction: mhat = round(|m| 2^24 / d1), vhat = round(v 2^24 / d2)
    // ------------------------------------------------------------------
    aeu_pkg::div_req_t mh_req, vh_req, up_req;
    aeu_pkg::div_rsp_t mh_rsp, vh_rsp, up_rsp;
    logic [DW-1:0]     mmag_c;
    logic              msign_c;

    assign msign_c = s5_m_reg[DW-1];
    assign mmag_c  = msign_c ? DW'(-s5_m_reg) : DW'(s5_m_reg);

    assign mh_req.valid = s5_vld_reg;
    assign mh_req.num   = {8'd0, mmag_c, 24'd0} + 64'(d1 >> 1);
    assign mh_req.den   = aeu_pkg::DIV_DW'(d1);
    assign mh_req.tag   = {s5_prm_reg, s5_idx_reg, msign_c};

    assign vh_req.valid = s5_vld_reg;
    assign vh_req.num   = {8'd0, s5_v_reg, 24'd0} + 64'(d2 >> 1);
    assign vh_req.den   = aeu_pkg::DIV_DW'(d2);
    assign vh_req.tag   = {s5_prm_reg, s5_idx_reg, msign_c};

    aeu_div u_mhat_div (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .req   (mh_req),
        .rsp   (mh_rsp)
    );

    aeu_div u_vhat_div (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .req   (vh_req),
        .rsp   (vh_rsp)
    );

    // Saturate the corrected moments; root of vhat in Q16.16 terms
    logic [MW-1:0] mh_c;
    logic [47:0]   vh_c;
    aeu_pkg::sq_req_t sq_req;
    aeu_pkg::sq_rsp_t sq_rsp;

    assign mh_c = (mh_rsp.ovf || (|mh_rsp.quot[47:MW])) ? '1 : mh_rsp.quot[MW-1:0];
    assign vh_c = vh_rsp.ovf ? '1 : vh_rsp.quot;

    assign sq_req.valid = vh_rsp.valid;
    assign sq_req.x     = {vh_c, 16'd0};
    assign sq_req.tag   = {mh_c, mh_rsp.tag};

    aeu_sqrt u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .req   (sq_req),
        .rsp   (sq_rsp)
    );

    // ------------------------------------------------------------------
    // P1: denominator and rate products (split to keep multipliers narrow)
    // ------------------------------------------------------------------
    logic [MW-1:0]          sq_mh;
    logic [DW+IW:0]         sq_side;
    logic [DW:0]            den_c;
    logic [RW+19:0]         plo_c;
    logic [RW+18:0]         phi_c;

    logic                   p1_vld_reg;
    logic [DW:0]            p1_den_reg;
    logic [RW+19:0]         p1_plo_reg;
    logic [RW+18:0]         p1_phi_reg;
    logic [DW+IW:0]         p1_side_reg;

    assign sq_mh   = sq_rsp.tag[aeu_pkg::SQ_TW-1:aeu_pkg::DIV_TW];
    assign sq_side = sq_rsp.tag[aeu_pkg::DIV_TW-1:0];
    assign plo_c   = (RW+20)'(rate_reg) * (RW+20)'(sq_mh[19:0]);
    assign phi_c   = (RW+19)'(rate_reg) * (RW+19)'(sq_mh[MW-1:20]);

    always_comb
    begin
        den_c = (DW+1)'(sq_rsp.root) + (DW+1)'(eps_reg);
        if (den_c == '0)
        begin
            den_c = (DW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_vld_reg <= sq_rsp.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_den_reg  <= den_c;
            p1_plo_reg  <= plo_c;
            p1_phi_reg  <= phi_c;
            p1_side_reg <= sq_side;
        end
    end

    // step = round(rate * mhat / (den * 2^8))
    assign up_req.valid = p1_vld_reg;
    assign up_req.num   = 64'(p1_plo_reg) + {1'd0, p1_phi_reg, 20'd0}
                        + 64'({p1_den_reg, 7'd0});
    assign up_req.den   = {p1_den_reg, 8'd0};
    assign up_req.tag   = p1_side_reg;

    aeu_div u_step_div (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .req   (up_req),
        .rsp   (up_rsp)
    );

    // ------------------------------------------------------------------
    // Apply the step against the sign of m, clamp, and register the result
    // ------------------------------------------------------------------
    logic [32:0]          upd_c;
    logic signed [DW-1:0] prm_c;
    logic [IW-1:0]        idx_c;
    logic                 sign_c;
    logic signed [34:0]   res_c;
    logic signed [DW-1:0] resc_c;

    logic                 out_vld_reg;
    logic [IW-1:0]        out_idx_reg;
    logic signed [DW-1:0] out_val_reg;

    assign last_vld = up_rsp.valid;
    assign prm_c    = up_rsp.tag[DW+IW:IW+1];
    assign idx_c    = up_rsp.tag[IW:1];
    assign sign_c   = up_rsp.tag[0];

    // Any step of 2^32 or more already drives the result to a rail.
    assign upd_c = (up_rsp.ovf || (|up_rsp.quot[47:33])) ? 33'h100000000
                                                         : up_rsp.quot[32:0];
    assign res_c = sign_c ? (35'(prm_c) + $signed({2'b00, upd_c}))
                          : (35'(prm_c) - $signed({2'b00, upd_c}));

    always_comb
    begin
        if (res_c > 35'sd2147483647)
        begin
            resc_c = 32'sh7FFFFFFF;
        end
        else if (res_c < -35'sd2147483648)
        begin
            resc_c = 32'sh80000000;
        end
        else
        begin
            resc_c = DW'(res_c);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv && last_vld)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && last_vld)
        begin
            out_idx_reg <= idx_c;
            out_val_reg <= resc_c;
        end
    end

    assign out_valid       = out_vld_reg;
    assign result_index    = out_idx_reg;
    assign new_param_value = out_val_reg;

endmodule

// ===== rtl/aeu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aeu_checker : port-level checks of the Adam update unit
// Watches result hold, step ordering, known result payload and register
// read-back.
// ----------------------------------------------------------------------------
module aeu_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              req_type,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [aeu_pkg::IDX_W-1:0]         result_index,
    input logic signed [aeu_pkg::DATA_W-1:0] new_param_value,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [aeu_pkg::PADDR_W-1:0]       paddr,
    input logic [31:0]                       pwdata,
    input logic [31:0]                       prdata,
    input logic                              pready
);

    // Hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_index)
                                    && $stable(new_param_value))
        else $error("result beat changed while stalled");

    // A begin-step beat is only taken with no element in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type == aeu_pkg::REQ_BEGIN_STEP
        |=> !$rose(out_valid))
        else $error("result appeared right after a begin-step beat");

    // A presented result beat carries a known payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({result_index, new_param_value}))
        else $error("result beat with unknown payload");

    // Read back the epsilon register just written
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready
        && paddr[3:2] == aeu_pkg::REG_EPSILON
        |=> (paddr[3:2] != aeu_pkg::REG_EPSILON)
            || (prdata == {16'd0, $past(pwdata[15:0])}))
        else $error("epsilon read-back mismatch");

endmodule

bind adam_elementwise_update_unit aeu_checker u_aeu_checker (.*);

// ===== tb/adam_elementwise_update_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_elementwise_update_unit_test : self-checking bench of the Adam unit
// Drives begin-step and element beats under random idling, predicts each new
// parameter in fixed point alongside the block, and compares result beats in
// order. Decay and epsilon registers are rewritten between phases.
// ----------------------------------------------------------------------------
module adam_elementwise_update_unit_test;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic req_type = aeu_pkg::REQ_BEGIN_STEP;
    logic [aeu_pkg::IDX_W-1:0] element_index = '0;
    logic signed [aeu_pkg::DATA_W-1:0] gradient = '0;
    logic signed [aeu_pkg::DATA_W-1:0] param_value = '0;
    logic [aeu_pkg::RATE_W-1:0] step_lr = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [aeu_pkg::IDX_W-1:0] result_index;
    logic signed [aeu_pkg::DATA_W-1:0] new_param_value;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [aeu_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    adam_elementwise_update_unit dut (.*);

    always #6 clk = ~clk;

    // Predictor state, mirroring the block's own stores
    logic [31:0] mom1 [aeu_pkg::ELEMENTS];
    logic [31:0] mom2 [aeu_pkg::ELEMENTS];
    logic [31:0] steps;
    logic [24:0] pow1, pow2;
    logic [23:0] rate, b1, b2;
    logic [15:0] eps;

    logic [aeu_pkg::IDX_W-1:0] want_index [$];
    logic [31:0] want_param [$];
    int errors = 0;
    int send_idle = 0;      // percent chance of a gap before each beat
    int recv_stall = 0;     // percent chance of holding ready low

    function automatic longint clamp_s32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic logic [63:0] round_div(logic [63:0] n, logic [63:0] d);
        logic [127:0] w;
        w = {64'd0, n} + {64'd0, d >> 1};
        return 64'(w / {64'd0, d});
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r, bit_v;
        r = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > x) bit_v >>= 2;
        while (bit_v != 0) begin
            if (x >= r + bit_v) begin
                x -= r + bit_v;
                r = (r >> 1) + bit_v;
            end else begin
                r >>= 1;
            end
            bit_v >>= 2;
        end
        return r;
    endfunction

    // Advance the optimiser step, or update one element and queue its result
    task automatic adam_predict(logic kind, logic [11:0] idx, logic [31:0] g_raw,
                                logic [31:0] p_raw, logic [23:0] lr);
        longint g, prm, mold, mnew, acc, res;
        logic [63:0] gmag, gsq, vnew, p1, p2, d1, d2, mmag, mh, vh, den, upd;
        logic [127:0] vsum;
        if (kind == aeu_pkg::REQ_BEGIN_STEP) begin
            if (steps != 32'hFFFF_FFFF) steps++;
            pow1 = 25'((({39'd0, pow1} * b1) + 64'(aeu_pkg::HALF_Q24)) >> 24);
            pow2 = 25'((({39'd0, pow2} * b2) + 64'(aeu_pkg::HALF_Q24)) >> 24);
            rate = lr;
            return;
        end
        g = longint'($signed(g_raw));
        prm = longint'($signed(p_raw));
        mold = longint'($signed(mom1[idx]));
        acc = longint'(b1) * mold + (longint'(1 << 24) - longint'(b1)) * g + (1 << 23);
        mnew = clamp_s32(acc >>> 24);
        mom1[idx] = 32'(mnew);
        gmag = (g < 0) ? 64'(-g) : 64'(g);
        gsq = (gmag * gmag + 64'd32768) >> 16;
        if (gsq > 64'hFFFF_FFFF) gsq = 64'hFFFF_FFFF;
        vsum = 128'(b2) * mom2[idx] + 128'((1 << 24) - b2) * gsq;
        vnew = 64'((vsum + (1 << 23)) >> 24);
        if (vnew > 64'hFFFF_FFFF) vnew = 64'hFFFF_FFFF;
        mom2[idx] = 32'(vnew);
        p1 = (steps != 0) ? 64'(pow1) : 64'(b1);
        p2 = (steps != 0) ? 64'(pow2) : 64'(b2);
        d1 = (p1 >= (1 << 24)) ? 64'd1 : (1 << 24) - p1;
        d2 = (p2 >= (1 << 24)) ? 64'd1 : (1 << 24) - p2;
        mmag = (mnew < 0) ? 64'(-mnew) : 64'(mnew);
        mh = round_div(mmag << 24, d1);
        if (mh > 64'h7F_FFFF_FFFF) mh = 64'h7F_FFFF_FFFF;
        vh = round_div(vnew << 24, d2);
        if (vh > 64'hFFFF_FFFF_FFFF) vh = 64'hFFFF_FFFF_FFFF;
        den = int_sqrt(vh << 16) + eps;
        if (den == 0) den = 1;
        upd = round_div(64'(rate) * mh, den << 8);
        res = (mnew < 0) ? prm + longint'(upd) : prm - longint'(upd);
        want_index.push_back(idx);
        want_param.push_back(32'(clamp_s32(res)));
    endtask

    // Send one request beat; drop valid only for a random gap first
    task automatic send_beat(logic kind, logic [11:0] idx, logic [31:0] g,
                             logic [31:0] p, logic [23:0] lr);
        if ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        element_index <= idx;
        gradient <= g;
        param_value <= p;
        step_lr <= lr;
        do @(posedge clk); while (!in_ready);
        adam_predict(kind, idx, g, p, lr);
    endtask

    // Hold until every expected beat has come back, then let the pipe drain
    task automatic drain();
        in_valid <= 1'b0;
        while (want_index.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(aeu_pkg::reg_idx_t r, logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {r, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            aeu_pkg::REG_BETA_FIRST:  b1 = val[23:0];
            aeu_pkg::REG_BETA_SECOND: b2 = val[23:0];
            aeu_pkg::REG_EPSILON:     eps = val[15:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(131072)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    // Receiver: stall at random, check each result beat against the oldest
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (want_index.size() == 0) begin
                $error("unexpected result beat, index %0d", result_index);
                errors++;
            end else begin
                if (result_index !== want_index[0]) begin
                    $error("result_index expected %0d got %0d",
                           want_index[0], result_index);
                    errors++;
                end
                if (new_param_value !== want_param[0]) begin
                    $error("new_param_value expected %0d got %0d",
                           $signed(want_param[0]), new_param_value);
                    errors++;
                end
                void'(want_index.pop_front());
                void'(want_param.pop_front());
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall);
    end

    // Directed: extremes, steps, element before any step, index reuse
    task automatic test_directed();
        send_beat(aeu_pkg::REQ_ELEMENT, 12'd0, 32'h0001_0000, 32'h0002_0000, 24'd0);
        send_beat(aeu_pkg::REQ_BEGIN_STEP, 12'd0, 32'd0, 32'd0, 24'hFF_FFFF);
        send_beat(aeu_pkg::REQ_ELEMENT, 12'd0, 32'h0001_0000, 32'h0002_0000, 24'd0);
        send_beat(aeu_pkg::REQ_ELEMENT, 12'hFFF, 32'h7FFF_FFFF, 32'h8000_0000, 24'd0);
        send_beat(aeu_pkg::REQ_ELEMENT, 12'hFFF, 32'h8000_0000, 32'h7FFF_FFFF, 24'd0);
        send_beat(aeu_pkg::REQ_ELEMENT, 12'd1, 32'h8000_0000, 32'h8000_0000, 24'd0);
        send_beat(aeu_pkg::REQ_ELEMENT, 12'd2, 32'd0, 32'h7FFF_FFFF, 24'd0);
        send_beat(aeu_pkg::REQ_ELEMENT, 12'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'd0);
        send_beat(aeu_pkg::REQ_BEGIN_STEP, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'd1);
        send_beat(aeu_pkg::REQ_ELEMENT, 12'hAAA, 32'h5555_5555, 32'hAAAA_AAAA, 24'hFF_FFFF);
        send_beat(aeu_pkg::REQ_ELEMENT, 12'h555, 32'hAAAA_AAAA, 32'h5555_5555, 24'd0);
        drain();
    endtask

    // Decay at one means the correction denominator would be zero
    task automatic test_corner_config();
        write_reg(aeu_pkg::REG_BETA_FIRST, 32'hFFFF_FFFF);
        write_reg(aeu_pkg::REG_BETA_SECOND, 32'h00FF_FFFF);
        write_reg(aeu_pkg::REG_EPSILON, 32'h0000_FFFF);
        send_beat(aeu_pkg::REQ_BEGIN_STEP, 12'd0, 32'd0, 32'd0, 24'h80_0000);
        send_beat(aeu_pkg::REQ_ELEMENT, 12'd7, 32'h0100_0000, 32'd0, 24'd0);
        send_beat(aeu_pkg::REQ_ELEMENT, 12'd7, 32'hFF00_0000, 32'd0, 24'd0);
        drain();
        write_reg(aeu_pkg::REG_BETA_FIRST, 32'd0);
        write_reg(aeu_pkg::REG_BETA_SECOND, 32'd0);
        write_reg(aeu_pkg::REG_EPSILON, 32'd0);
        send_beat(aeu_pkg::REQ_ELEMENT, 12'd9, 32'd0, 32'd12345, 24'd0);
        send_beat(aeu_pkg::REQ_BEGIN_STEP, 12'd0, 32'd0, 32'd0, 24'h12_3456);
        send_beat(aeu_pkg::REQ_ELEMENT, 12'd9, 32'h0003_0000, 32'd12345, 24'd0);
        drain();
    endtask

    // Random steps of elements, mostly on a small set of slots for reuse
    task automatic test_random(int beats, int idle, int stall);
        logic [11:0] idx;
        send_idle = idle;
        recv_stall = stall;
        for (int i = 0; i < beats; i++) begin
            idx = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(15));
            if ($urandom_range(19) == 0)
                send_beat(aeu_pkg::REQ_BEGIN_STEP, idx, rand_word(), rand_word(),
                          24'($urandom));
            else
                send_beat(aeu_pkg::REQ_ELEMENT, idx, rand_word(), rand_word(),
                          24'($urandom));
            if (i == beats / 2 && idle == 0) begin
                in_valid <= 1'b0;
                while (want_index.size() != 0) @(posedge clk);
            end
        end
        drain();
    endtask

    initial begin
        for (int i = 0; i < aeu_pkg::ELEMENTS; i++) begin
            mom1[i] = '0;
            mom2[i] = '0;
        end
        steps = 0;
        pow1 = aeu_pkg::ONE_Q24;
        pow2 = aeu_pkg::ONE_Q24;
        rate = 0;
        b1 = aeu_pkg::BETA_FIRST_RST;
        b2 = aeu_pkg::BETA_SECOND_RST;
        eps = aeu_pkg::EPSILON_RST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(220, 0, 0);
        test_corner_config();
        write_reg(aeu_pkg::REG_BETA_FIRST, 32'd15099494);
        write_reg(aeu_pkg::REG_BETA_SECOND, 32'd16760438);
        write_reg(aeu_pkg::REG_EPSILON, 32'd1);
        test_random(220, 53, 0);
        write_reg(aeu_pkg::REG_BETA_FIRST, 32'($urandom));
        write_reg(aeu_pkg::REG_BETA_SECOND, 32'd16000000);
        write_reg(aeu_pkg::REG_EPSILON, 32'd300);
        test_random(220, 0, 53);
        write_reg(aeu_pkg::REG_EPSILON, 32'd1);
        test_random(220, 7, 7);
        if (errors == 0)
            $display("adam_elementwise_update_unit_test: clean");
        else
            $display("adam_elementwise_update_unit_test: errors");
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("adam_elementwise_update_unit_test: errors");
        $finish;
    end

endmodule
